[design/prp_pkg.sv]
// Shared types and constants for the packet receive parser.
package prp_pkg;

	// control bytes and TLV types
	localparam logic [7:0] CTRL_DATA  = 8'h01;
	localparam logic [7:0] CTRL_START = 8'h02;
	localparam logic [7:0] CTRL_END   = 8'h03;
	localparam logic [7:0] TLV_SIZE   = 8'h00;
	localparam logic [7:0] TLV_NAME   = 8'h01;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_NAME    = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// packet status codes
	localparam logic [2:0] ST_START_OK  = 3'd0;
	localparam logic [2:0] ST_DATA_OK   = 3'd1;
	localparam logic [2:0] ST_END       = 3'd2;
	localparam logic [2:0] ST_BAD_SEQ   = 3'd3;
	localparam logic [2:0] ST_LEN_ERR   = 3'd4;
	localparam logic [2:0] ST_NO_NAME   = 3'd5;
	localparam logic [2:0] ST_IGNORED   = 3'd6;
	localparam logic [2:0] ST_SIZE_LONG = 3'd7;
	localparam logic [2:0] ST_NONE      = 3'd0;

	// parse steps while waiting for a start packet
	localparam logic [2:0] WS_CTRL      = 3'd0;
	localparam logic [2:0] WS_SIZE_TYPE = 3'd1;
	localparam logic [2:0] WS_SIZE_LEN  = 3'd2;
	localparam logic [2:0] WS_SIZE_VAL  = 3'd3;
	localparam logic [2:0] WS_NAME_TYPE = 3'd4;
	localparam logic [2:0] WS_NAME_LEN  = 3'd5;
	localparam logic [2:0] WS_NAME      = 3'd6;
	localparam logic [2:0] WS_SKIP      = 3'd7;

	// parse steps while receiving data packets
	localparam logic [2:0] RS_CTRL    = 3'd0;
	localparam logic [2:0] RS_SEQ     = 3'd1;
	localparam logic [2:0] RS_LEN_HI  = 3'd2;
	localparam logic [2:0] RS_LEN_LO  = 3'd3;
	localparam logic [2:0] RS_PAYLOAD = 3'd4;
	localparam logic [2:0] RS_SKIP    = 3'd5;

	localparam logic [16:0] POS_MAX = 17'h1FFFF;

	// output tdata: out_byte, status, seq_expected, file_size, total_bytes
	localparam int unsigned OUT_BITS  = 83;
	localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;
	localparam int unsigned OUT_W     = OUT_BYTES * 8;

	typedef enum logic [1:0] {
		PH_WAIT = 2'b01,
		PH_RECV = 2'b10
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic [2:0]  status;
		logic [7:0]  seq_expected;
		logic [31:0] file_size;
		logic [31:0] total_bytes;
	} result_t;

endpackage

[design/packet_receive_parser.sv]
// Packet receive parser: start/data/end packet deframer with TLV header decode.
// Throughput: one input item per cycle while tready is high; an item that yields
// two results (last name or payload byte plus status) queues both of them.
// Results of an accepted item are registered into a four-entry result queue
// that drives the master side; tready is high while the queue holds at most two
// results.
// Reset: arst_n asynchronously clears the parser state and empties the queue.
module packet_receive_parser #(
	parameter int unsigned SIZE_OCTETS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
	input  logic                       s_axis_tlast,  // end_of_packet
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// [7:0] out_byte, [10:8] status, [18:11] seq_expected, [50:19] file_size,
	// [82:51] total_bytes, [87:83] zero
	output logic [prp_pkg::OUT_W-1:0]  m_axis_tdata,
	output logic [1:0]                 m_axis_tuser   // [1:0] kind
);

	localparam logic [7:0] SIZE_MAX = 8'(SIZE_OCTETS);

	// parser state
	prp_pkg::phase_t phase_q, n_phase;
	logic [2:0]  step_q, n_step;
	logic [7:0]  ctrl_q, n_ctrl;
	logic [16:0] pos_q, n_pos;
	logic [7:0]  seq_q, n_seq;
	logic [15:0] dlen_q, n_dlen;
	logic [7:0]  frem_q, n_frem;
	logic [31:0] sacc_q, n_sacc;
	logic [2:0]  perr_q, n_perr;
	logic [31:0] total_q, n_total;

	logic        emit;
	logic [1:0]  emit_kind;
	logic [2:0]  st;
	logic [32:0] sum;
	logic [7:0]  b;
	logic        last;

	prp_pkg::result_t res_a, res_b;

	// result queue
	prp_pkg::result_t fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       accept, pop;
	logic [1:0] n_push;

	assign b    = s_axis_tdata;
	assign last = s_axis_tlast;

	always_comb begin
		n_phase   = phase_q;
		n_step    = step_q;
		n_ctrl    = ctrl_q;
		n_pos     = pos_q;
		n_seq     = seq_q;
		n_dlen    = dlen_q;
		n_frem    = frem_q;
		n_sacc    = sacc_q;
		n_perr    = perr_q;
		n_total   = total_q;
		emit      = 1'b0;
		emit_kind = prp_pkg::KIND_PAYLOAD;
		st        = prp_pkg::ST_START_OK;
		sum       = '0;

		if (phase_q == prp_pkg::PH_WAIT) begin
			case (step_q)
				prp_pkg::WS_CTRL: begin
					n_ctrl = b;
					n_sacc = '0;
					n_step = (b == prp_pkg::CTRL_START) ? prp_pkg::WS_SIZE_TYPE
						: prp_pkg::WS_SKIP;
				end
				prp_pkg::WS_SIZE_TYPE: begin
					n_step = (b == prp_pkg::TLV_SIZE) ? prp_pkg::WS_SIZE_LEN
						: prp_pkg::WS_SKIP;
				end
				prp_pkg::WS_SIZE_LEN: begin
					if (b > SIZE_MAX) begin
						n_perr = prp_pkg::ST_SIZE_LONG;
						n_step = prp_pkg::WS_SKIP;
					end else if (b == 8'd0) begin
						n_step = prp_pkg::WS_NAME_TYPE;
					end else begin
						n_frem = b;
						n_step = prp_pkg::WS_SIZE_VAL;
					end
				end
				prp_pkg::WS_SIZE_VAL: begin
					// keep the low 32 bits of the big-endian value
					n_sacc = {sacc_q[23:0], b};
					n_frem = frem_q - 8'd1;
					if (frem_q == 8'd1) n_step = prp_pkg::WS_NAME_TYPE;
				end
				prp_pkg::WS_NAME_TYPE: begin
					if (b != prp_pkg::TLV_NAME) begin
						n_perr = prp_pkg::ST_NO_NAME;
						n_step = prp_pkg::WS_SKIP;
					end else begin
						n_step = prp_pkg::WS_NAME_LEN;
					end
				end
				prp_pkg::WS_NAME_LEN: begin
					n_frem = b;
					n_step = (b == 8'd0) ? prp_pkg::WS_SKIP : prp_pkg::WS_NAME;
				end
				prp_pkg::WS_NAME: begin
					emit      = 1'b1;
					emit_kind = prp_pkg::KIND_NAME;
					n_frem    = frem_q - 8'd1;
					if (frem_q == 8'd1) n_step = prp_pkg::WS_SKIP;
				end
				default: ;
			endcase
		end else begin
			case (step_q)
				prp_pkg::RS_CTRL: begin
					n_ctrl = b;
					n_step = (b == prp_pkg::CTRL_DATA) ? prp_pkg::RS_SEQ
						: prp_pkg::RS_SKIP;
				end
				prp_pkg::RS_SEQ: begin
					if (b != seq_q) n_perr = prp_pkg::ST_BAD_SEQ;
					n_step = prp_pkg::RS_LEN_HI;
				end
				prp_pkg::RS_LEN_HI: begin
					n_dlen = {b, 8'd0};
					n_step = prp_pkg::RS_LEN_LO;
				end
				prp_pkg::RS_LEN_LO: begin
					n_dlen = {dlen_q[15:8], b};
					n_pos  = '0;
					n_step = prp_pkg::RS_PAYLOAD;
				end
				prp_pkg::RS_PAYLOAD: begin
					emit      = (perr_q == prp_pkg::ST_NONE);
					emit_kind = prp_pkg::KIND_PAYLOAD;
					if (pos_q < prp_pkg::POS_MAX) n_pos = pos_q + 17'd1;
				end
				default: ;
			endcase
		end

		res_a.kind         = emit_kind;
		res_a.out_byte     = b;
		res_a.status       = prp_pkg::ST_NONE;
		res_a.seq_expected = n_seq;
		res_a.file_size    = n_sacc;
		res_a.total_bytes  = n_total;

		if (last) begin
			if (phase_q == prp_pkg::PH_WAIT) begin
				if (n_ctrl != prp_pkg::CTRL_START) begin
					st = prp_pkg::ST_IGNORED;
				end else if (n_perr != prp_pkg::ST_NONE) begin
					st = n_perr;
				end else if (n_step inside {[prp_pkg::WS_SIZE_LEN : prp_pkg::WS_NAME_LEN]}) begin
					st = prp_pkg::ST_NO_NAME;
				end else begin
					st      = prp_pkg::ST_START_OK;
					n_phase = prp_pkg::PH_RECV;
					n_seq   = '0;
					n_total = '0;
				end
			end else begin
				if (n_ctrl == prp_pkg::CTRL_END) begin
					st      = prp_pkg::ST_END;
					n_phase = prp_pkg::PH_WAIT;
				end else if (n_ctrl != prp_pkg::CTRL_DATA) begin
					st = prp_pkg::ST_IGNORED;
				end else if (n_perr != prp_pkg::ST_NONE) begin
					st      = n_perr;
					n_phase = prp_pkg::PH_WAIT;
				end else if (n_step != prp_pkg::RS_PAYLOAD || n_pos != {1'b0, n_dlen}) begin
					st      = prp_pkg::ST_LEN_ERR;
					n_phase = prp_pkg::PH_WAIT;
				end else begin
					st      = prp_pkg::ST_DATA_OK;
					n_seq   = seq_q + 8'd1;
					// saturate the running total
					sum     = {1'b0, n_total} + {16'd0, n_pos};
					n_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
			n_step = prp_pkg::WS_CTRL;
			n_perr = prp_pkg::ST_NONE;
			n_frem = '0;
			n_pos  = '0;
		end

		res_b.kind         = prp_pkg::KIND_STATUS;
		res_b.out_byte     = '0;
		res_b.status       = st;
		res_b.seq_expected = n_seq;
		res_b.file_size    = n_sacc;
		res_b.total_bytes  = n_total;
	end

	assign s_axis_tready = (count_q < 3'd3);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (count_q != 3'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign n_push        = accept ? ({1'b0, emit} + {1'b0, last}) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= prp_pkg::PH_WAIT;
			step_q  <= '0;
			ctrl_q  <= '0;
			pos_q   <= '0;
			seq_q   <= '0;
			dlen_q  <= '0;
			frem_q  <= '0;
			sacc_q  <= '0;
			perr_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			phase_q <= n_phase;
			step_q  <= n_step;
			ctrl_q  <= n_ctrl;
			pos_q   <= n_pos;
			seq_q   <= n_seq;
			dlen_q  <= n_dlen;
			frem_q  <= n_frem;
			sacc_q  <= n_sacc;
			perr_q  <= n_perr;
			total_q <= n_total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, n_push} - {2'b0, pop};
		end
	end

	// write the byte result first, then the status result
	always_ff @(posedge clk) begin
		if (accept) begin
			if (emit) begin
				fifo_q[wr_ptr_q] <= res_a;
				if (last) fifo_q[wr_ptr_q + 2'd1] <= res_b;
			end else if (last) begin
				fifo_q[wr_ptr_q] <= res_b;
			end
		end
	end

	assign m_axis_tuser = fifo_q[rd_ptr_q].kind;
	assign m_axis_tdata = {5'd0, fifo_q[rd_ptr_q].total_bytes, fifo_q[rd_ptr_q].file_size,
		fifo_q[rd_ptr_q].seq_expected, fifo_q[rd_ptr_q].status,
		fifo_q[rd_ptr_q].out_byte};

endmodule

[design/prp_checker.sv]
// Port-level checker for the packet receive parser, bound to the top level.
module prp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [7:0]                s_axis_tdata,
	input logic                      s_axis_tlast,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [prp_pkg::OUT_W-1:0] m_axis_tdata,
	input logic [1:0]                m_axis_tuser
);

	// hold a stalled result item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result item changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined result kind");

	a_byte_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != prp_pkg::KIND_STATUS |-> m_axis_tdata[10:8] == 3'd0)
		else $error("byte item carries a status code");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == prp_pkg::KIND_STATUS |-> m_axis_tdata[7:0] == 8'd0)
		else $error("status item carries a data byte");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[prp_pkg::OUT_W-1:prp_pkg::OUT_BITS] == '0)
		else $error("nonzero tdata padding");

endmodule

bind packet_receive_parser prp_checker u_prp_checker (.*);

[tb/packet_receive_parser_tb.sv]
// Self-checking testbench for the packet receive parser: directed packets, then random traffic.
module packet_receive_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SIZE_OCTETS = 4;

	typedef struct packed {
		logic [7:0] rx;
		logic       eop;
		logic       typed;
		logic [2:0] want;
	} stim_row_t;

	// status is typed in on the last byte of each packet; name and payload
	// results come from the parser model
	localparam stim_row_t DIRECTED [26] = '{
		'{prp_pkg::CTRL_END,   1'b1, 1'b1, prp_pkg::ST_IGNORED},
		'{prp_pkg::CTRL_START, 1'b0, 1'b0, prp_pkg::ST_NONE},
		'{prp_pkg::TLV_SIZE,   1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h05,               1'b1, 1'b1, prp_pkg::ST_SIZE_LONG},
		'{prp_pkg::CTRL_START, 1'b0, 1'b0, prp_pkg::ST_NONE},
		'{prp_pkg::TLV_SIZE,   1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h00,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h07,               1'b1, 1'b1, prp_pkg::ST_NO_NAME},
		'{prp_pkg::CTRL_START, 1'b0, 1'b0, prp_pkg::ST_NONE},
		'{prp_pkg::TLV_SIZE,   1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h02,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'hFF,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'hFF,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{prp_pkg::TLV_NAME,   1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h01,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'hAB,               1'b1, 1'b1, prp_pkg::ST_START_OK},
		'{prp_pkg::CTRL_DATA,  1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h00,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h00,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h01,               1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'hFF,               1'b1, 1'b1, prp_pkg::ST_DATA_OK},
		'{prp_pkg::CTRL_END,   1'b1, 1'b1, prp_pkg::ST_END},
		'{prp_pkg::CTRL_START, 1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h05,               1'b1, 1'b1, prp_pkg::ST_START_OK},
		'{prp_pkg::CTRL_DATA,  1'b0, 1'b0, prp_pkg::ST_NONE},
		'{8'h09,               1'b1, 1'b1, prp_pkg::ST_BAD_SEQ}
	};

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [7:0]                s_axis_tdata = 8'h00;
	logic                      s_axis_tlast = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [prp_pkg::OUT_W-1:0] m_axis_tdata;
	logic [1:0]                m_axis_tuser;

	// parser model state
	prp_pkg::phase_t rx_phase = prp_pkg::PH_WAIT;
	logic [2:0]  step = prp_pkg::WS_CTRL;
	logic [7:0]  ctrl = 8'h00;
	logic [16:0] pos = '0;
	logic [7:0]  seq_next = 8'h00;
	logic [15:0] decl_len = '0;
	logic [7:0]  remaining = 8'h00;
	logic [31:0] size_acc = '0;
	logic [2:0]  pkt_err = prp_pkg::ST_NONE;
	logic [31:0] total = '0;

	prp_pkg::result_t outputs_due [$];
	int      mismatches = 0;
	int      items_sent = 0;
	bit      calm = 1'b0;
	bit      stall_req = 1'b0;

	packet_receive_parser #(
		.SIZE_OCTETS(SIZE_OCTETS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic prp_pkg::result_t snapshot(logic [1:0] k, logic [7:0] b, logic [2:0] s);
		prp_pkg::result_t r;
		r.kind = k;
		r.out_byte = b;
		r.status = s;
		r.seq_expected = seq_next;
		r.file_size = size_acc;
		r.total_bytes = total;
		return r;
	endfunction

	// Advance the parser model by one accepted item and queue its results.
	task automatic parse_rx_byte(input logic [7:0] b, input logic eop, input logic typed,
			input logic [2:0] want);
		logic [2:0]  st;
		logic [32:0] sum;
		if (rx_phase == prp_pkg::PH_WAIT) begin
			case (step)
				prp_pkg::WS_CTRL: begin
					ctrl = b;
					size_acc = '0;
					step = (b == prp_pkg::CTRL_START) ? prp_pkg::WS_SIZE_TYPE
						: prp_pkg::WS_SKIP;
				end
				prp_pkg::WS_SIZE_TYPE: step = (b == prp_pkg::TLV_SIZE) ? prp_pkg::WS_SIZE_LEN
					: prp_pkg::WS_SKIP;
				prp_pkg::WS_SIZE_LEN: begin
					if (b > SIZE_OCTETS) begin
						pkt_err = prp_pkg::ST_SIZE_LONG;
						step = prp_pkg::WS_SKIP;
					end else if (b == 8'h00) begin
						step = prp_pkg::WS_NAME_TYPE;
					end else begin
						remaining = b;
						step = prp_pkg::WS_SIZE_VAL;
					end
				end
				prp_pkg::WS_SIZE_VAL: begin
					size_acc = {size_acc[23:0], b};
					remaining = remaining - 8'd1;
					if (remaining == 8'h00)
						step = prp_pkg::WS_NAME_TYPE;
				end
				prp_pkg::WS_NAME_TYPE: begin
					if (b != prp_pkg::TLV_NAME) begin
						pkt_err = prp_pkg::ST_NO_NAME;
						step = prp_pkg::WS_SKIP;
					end else begin
						step = prp_pkg::WS_NAME_LEN;
					end
				end
				prp_pkg::WS_NAME_LEN: begin
					remaining = b;
					step = (b == 8'h00) ? prp_pkg::WS_SKIP : prp_pkg::WS_NAME;
				end
				prp_pkg::WS_NAME: begin
					outputs_due.push_back(snapshot(prp_pkg::KIND_NAME, b, prp_pkg::ST_NONE));
					remaining = remaining - 8'd1;
					if (remaining == 8'h00)
						step = prp_pkg::WS_SKIP;
				end
				default: ;
			endcase
		end else begin
			case (step)
				prp_pkg::RS_CTRL: begin
					ctrl = b;
					step = (b == prp_pkg::CTRL_DATA) ? prp_pkg::RS_SEQ : prp_pkg::RS_SKIP;
				end
				prp_pkg::RS_SEQ: begin
					if (b != seq_next)
						pkt_err = prp_pkg::ST_BAD_SEQ;
					step = prp_pkg::RS_LEN_HI;
				end
				prp_pkg::RS_LEN_HI: begin
					decl_len = {b, 8'h00};
					step = prp_pkg::RS_LEN_LO;
				end
				prp_pkg::RS_LEN_LO: begin
					decl_len[7:0] = b;
					pos = '0;
					step = prp_pkg::RS_PAYLOAD;
				end
				prp_pkg::RS_PAYLOAD: begin
					if (pkt_err == prp_pkg::ST_NONE)
						outputs_due.push_back(snapshot(prp_pkg::KIND_PAYLOAD, b,
							prp_pkg::ST_NONE));
					if (pos != prp_pkg::POS_MAX)
						pos = pos + 17'd1;
				end
				default: ;
			endcase
		end

		if (!eop)
			return;

		if (rx_phase == prp_pkg::PH_WAIT) begin
			if (ctrl != prp_pkg::CTRL_START) begin
				st = prp_pkg::ST_IGNORED;
			end else if (pkt_err != prp_pkg::ST_NONE) begin
				st = pkt_err;
			end else if (step >= prp_pkg::WS_SIZE_LEN && step <= prp_pkg::WS_NAME_LEN) begin
				st = prp_pkg::ST_NO_NAME;
			end else begin
				rx_phase = prp_pkg::PH_RECV;
				seq_next = 8'h00;
				total = '0;
				st = prp_pkg::ST_START_OK;
			end
		end else begin
			if (ctrl == prp_pkg::CTRL_END) begin
				rx_phase = prp_pkg::PH_WAIT;
				st = prp_pkg::ST_END;
			end else if (ctrl != prp_pkg::CTRL_DATA) begin
				st = prp_pkg::ST_IGNORED;
			end else if (pkt_err != prp_pkg::ST_NONE) begin
				rx_phase = prp_pkg::PH_WAIT;
				st = pkt_err;
			end else if (step != prp_pkg::RS_PAYLOAD || pos != {1'b0, decl_len}) begin
				rx_phase = prp_pkg::PH_WAIT;
				st = prp_pkg::ST_LEN_ERR;
			end else begin
				seq_next = seq_next + 8'd1;
				sum = {1'b0, total} + 33'(pos);
				total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				st = prp_pkg::ST_DATA_OK;
			end
		end
		step = prp_pkg::WS_CTRL;
		pkt_err = prp_pkg::ST_NONE;
		remaining = 8'h00;
		pos = '0;
		outputs_due.push_back(snapshot(prp_pkg::KIND_STATUS, 8'h00, typed ? want : st));
	endtask

	task automatic send_item(input logic [7:0] b, input logic eop, input logic typed,
			input logic [2:0] want);
		while (!calm && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eop;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		parse_rx_byte(b, eop, typed, want);
	endtask

	task automatic send_packet(input logic [7:0] pkt [$]);
		foreach (pkt[i])
			send_item(pkt[i], i == pkt.size() - 1, 1'b0, prp_pkg::ST_NONE);
	endtask

	task automatic cut_short(inout logic [7:0] pkt [$], input int keep);
		while (pkt.size() > keep)
			void'(pkt.pop_back());
	endtask

	task automatic send_start_packet();
		logic [7:0] pkt [$];
		int         flaw;
		int         n;
		logic [7:0] t;
		flaw = $urandom_range(99);
		pkt.push_back(flaw < 8 ? 8'($urandom) : prp_pkg::CTRL_START);
		pkt.push_back((flaw >= 8 && flaw < 14) ? 8'($urandom_range(1, 255))
			: prp_pkg::TLV_SIZE);
		if (flaw >= 14 && flaw < 20) begin
			pkt.push_back(8'($urandom_range(SIZE_OCTETS + 1, 255)));
			repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
		end else begin
			n = $urandom_range(0, SIZE_OCTETS);
			pkt.push_back(8'(n));
			repeat (n) pkt.push_back(8'($urandom));
			t = 8'($urandom);
			if (t == prp_pkg::TLV_NAME)
				t = ~t;
			pkt.push_back((flaw >= 20 && flaw < 26) ? t : prp_pkg::TLV_NAME);
			n = $urandom_range(0, 6);
			pkt.push_back(8'(n));
			repeat (n) pkt.push_back(8'($urandom));
			if (flaw >= 26 && flaw < 32)
				repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
		end
		if (flaw >= 32 && flaw < 40)
			cut_short(pkt, $urandom_range(1, pkt.size()));
		send_packet(pkt);
	endtask

	task automatic send_data_packet();
		logic [7:0]  pkt [$];
		int          flaw;
		int          n;
		logic [15:0] len;
		logic [7:0]  c;
		flaw = $urandom_range(99);
		if (flaw < 8) begin
			pkt.push_back(prp_pkg::CTRL_END);
			repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom));
		end else if (flaw < 13) begin
			c = 8'($urandom);
			pkt.push_back((c == prp_pkg::CTRL_DATA || c == prp_pkg::CTRL_END) ? 8'hC5 : c);
			repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
		end else begin
			n = ($urandom_range(19) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
			len = 16'(n);
			if (flaw >= 19 && flaw < 23)
				len = 16'($urandom);
			else if (flaw >= 23 && flaw < 26)
				len = $urandom_range(1) ? len + 16'd1 : len - 16'd1;
			pkt.push_back(prp_pkg::CTRL_DATA);
			pkt.push_back(flaw < 19 ? seq_next + 8'($urandom_range(1, 255)) : seq_next);
			pkt.push_back(len[15:8]);
			pkt.push_back(len[7:0]);
			repeat (n) pkt.push_back(8'($urandom));
			if (flaw >= 26 && flaw < 31)
				cut_short(pkt, $urandom_range(1, 3));
		end
		send_packet(pkt);
	endtask

	// stimulus
	initial begin
		logic [7:0] noise [$];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_item(DIRECTED[i].rx, DIRECTED[i].eop, DIRECTED[i].typed, DIRECTED[i].want);

		while (items_sent < 1400) begin
			if (items_sent >= 500)
				stall_req = 1'b1;
			calm = (items_sent >= 800 && items_sent < 1000);
			if ($urandom_range(99) < 4) begin
				noise.delete();
				repeat ($urandom_range(1, 5)) noise.push_back(8'($urandom));
				send_packet(noise);
			end else if (rx_phase == prp_pkg::PH_WAIT) begin
				send_start_packet();
			end else begin
				send_data_packet();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: random back-pressure plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_req && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				for (int k = 0; k < 300; k++)
					@(posedge clk);
			end
			m_axis_tready <= calm || ($urandom_range(99) >= 14);
		end
	end

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		prp_pkg::result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (outputs_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result kind %0h data %0h", $time, m_axis_tuser,
					m_axis_tdata);
			end else begin
				exp_r = outputs_due.pop_front();
				check_field("kind", 32'(exp_r.kind), 32'(m_axis_tuser));
				check_field("out_byte", 32'(exp_r.out_byte), 32'(m_axis_tdata[7:0]));
				check_field("status", 32'(exp_r.status), 32'(m_axis_tdata[10:8]));
				check_field("seq_expected", 32'(exp_r.seq_expected), 32'(m_axis_tdata[18:11]));
				check_field("file_size", exp_r.file_size, m_axis_tdata[50:19]);
				check_field("total_bytes", exp_r.total_bytes, m_axis_tdata[82:51]);
			end
		end
	end

endmodule

[packet_receive_parser.f]
design/prp_pkg.sv
design/packet_receive_parser.sv
design/prp_checker.sv
tb/packet_receive_parser_tb.sv
